// ===== rtl/sbsh_pkg.sv =====
package sbsh_pkg;

  typedef logic [31:0] word_t;

  // Input operation codes
  localparam logic OP_APPEND = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  // Padding constants
  localparam logic [7:0] PAD_MARK   = 8'h80;
  localparam logic [5:0] LEN_OFFSET = 6'd56;

  // Top level sequencer
  typedef enum logic [2:0] {
    S_IDLE,
    S_MARK,
    S_ZERO,
    S_LEN,
    S_LOAD,
    S_WAIT,
    S_EMIT
  } seq_state_e;

  // Compression core sequencer
  typedef enum logic [1:0] {
    C_IDLE,
    C_ROUND,
    C_FOLD
  } core_state_e;

  typedef struct packed {
    logic start;  // load block and begin the 64 rounds
    logic init;   // return the chaining words to their initial values
  } core_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;   // final fold cycle
  } core_stat_t;

  localparam word_t IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

endpackage

// ===== rtl/sbsh_core.sv =====
module sbsh_core import sbsh_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  core_ctrl_t     ctrl_i,
  input  logic [511:0]   block_i,
  output core_stat_t     stat_o,
  output word_t [7:0]    hash_o
);

  function automatic word_t ror(input word_t x, input int n);
    ror = (x >> n) | (x << (32 - n));
  endfunction

  core_state_e state_q, state_d;
  logic [5:0]  rnd_q, rnd_d;
  word_t [7:0] h_q, h_d;
  word_t [7:0] v_q, v_d;
  word_t       w_q [16];
  word_t       w_d [16];

  word_t big0, big1, ch, maj, t1, t2, sg0, sg1, w_new;

  // Round function and schedule extension on the shared datapath
  always_comb begin
    big1  = ror(v_q[4], 6) ^ ror(v_q[4], 11) ^ ror(v_q[4], 25);
    ch    = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
    t1    = v_q[7] + big1 + ch + K[rnd_q] + w_q[0];
    big0  = ror(v_q[0], 2) ^ ror(v_q[0], 13) ^ ror(v_q[0], 22);
    maj   = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
    t2    = big0 + maj;
    sg0   = ror(w_q[1], 7) ^ ror(w_q[1], 18) ^ (w_q[1] >> 3);
    sg1   = ror(w_q[14], 17) ^ ror(w_q[14], 19) ^ (w_q[14] >> 10);
    w_new = w_q[0] + sg0 + w_q[9] + sg1;
  end

  // Sequencer: load, 64 rounds, fold into chaining words
  always_comb begin
    state_d = state_q;
    rnd_d   = rnd_q;
    h_d     = h_q;
    v_d     = v_q;
    w_d     = w_q;
    case (state_q)
      C_IDLE: begin
        if (ctrl_i.init) begin
          for (int i = 0; i < 8; i++) h_d[i] = IV[i];
        end else if (ctrl_i.start) begin
          v_d = h_q;
          for (int i = 0; i < 16; i++) w_d[i] = block_i[511 - 32*i -: 32];
          rnd_d   = '0;
          state_d = C_ROUND;
        end
      end
      C_ROUND: begin
        v_d[7] = v_q[6];
        v_d[6] = v_q[5];
        v_d[5] = v_q[4];
        v_d[4] = v_q[3] + t1;
        v_d[3] = v_q[2];
        v_d[2] = v_q[1];
        v_d[1] = v_q[0];
        v_d[0] = t1 + t2;
        for (int i = 0; i < 15; i++) w_d[i] = w_q[i+1];
        w_d[15] = w_new;
        rnd_d   = rnd_q + 6'd1;
        if (rnd_q == 6'd63) state_d = C_FOLD;
      end
      C_FOLD: begin
        for (int i = 0; i < 8; i++) h_d[i] = h_q[i] + v_q[i];
        state_d = C_IDLE;
      end
      default: state_d = C_IDLE;
    endcase
  end

  // Control state and chaining words
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
      for (int i = 0; i < 8; i++) h_q[i] <= IV[i];
    end else begin
      state_q <= state_d;
      h_q     <= h_d;
    end
  end

  // Working variables and schedule window
  always_ff @(posedge clk_i) begin
    rnd_q <= rnd_d;
    v_q   <= v_d;
    w_q   <= w_d;
  end

  assign stat_o.busy = (state_q != C_IDLE);
  assign stat_o.done = (state_q == C_FOLD);
  assign hash_o      = h_q;

endmodule

// ===== rtl/sha256_byte_stream_hasher.sv =====
// SHA-256 over a byte stream.
// Input channel (in_valid_i / in_stall_o): one word per item. op 0 appends
// data_byte to the message; op 1 pads, finishes the message and starts a new
// one. A word is taken on a clock edge with valid high and stall low.
// Output channel (out_valid_o / out_stall_i): on finish, eight digest words,
// index 0 (most significant) first, last_word set on index 7.
// An append does not stall the input, except the 64th byte of a block,
// which holds stall while the shared round unit runs one round per cycle
// (load, 64 rounds, fold).
// A finish feeds the padding bytes one per cycle, unless a compression holds
// them, through the same buffer (plus one or two compressions) and then
// queues the digest words at one per cycle, while the output register is free.
// The output register lets a new message start while the last digest word
// waits; a stalled receiver only holds the digest phase of a later finish.
// Reset: asynchronous, active low; chaining words return to their initial
// values, length and fill count to zero, no output word pending.
module sha256_byte_stream_hasher import sbsh_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        op_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);

  seq_state_e   state_q, state_d, ret_q, ret_d;
  logic [5:0]   fill_q, fill_d;
  logic [63:0]  len_q, len_d;      // bit length, wraps mod 2^64
  logic [511:0] blk_q, blk_d;
  logic [2:0]   lidx_q, lidx_d;
  logic [2:0]   widx_q, widx_d;
  logic         out_valid_q, out_valid_d;
  word_t        out_word_q, out_word_d;
  logic [2:0]   out_idx_q, out_idx_d;
  logic         out_last_q, out_last_d;

  logic         push;
  logic [7:0]   push_byte;
  logic         in_acc;
  logic         out_free;
  core_ctrl_t   core_ctrl;
  core_stat_t   core_stat;
  word_t [7:0]  core_hash;

  sbsh_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (core_ctrl),
    .block_i (blk_q),
    .stat_o  (core_stat),
    .hash_o  (core_hash)
  );

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // Sequencer: appends, padding, compression hand-off, digest output
  always_comb begin
    state_d     = state_q;
    ret_d       = ret_q;
    fill_d      = fill_q;
    len_d       = len_q;
    blk_d       = blk_q;
    lidx_d      = lidx_q;
    widx_d      = widx_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_word_d  = out_word_q;
    out_idx_d   = out_idx_q;
    out_last_d  = out_last_q;
    push        = 1'b0;
    push_byte   = '0;
    core_ctrl   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (op_i == OP_FINISH) begin
            state_d = S_MARK;
          end else begin
            push      = 1'b1;
            push_byte = data_byte_i;
            len_d     = len_q + 64'd8;
            ret_d     = S_IDLE;
          end
        end
      end
      S_MARK: begin
        push      = 1'b1;
        push_byte = PAD_MARK;
        ret_d     = S_ZERO;
        state_d   = S_ZERO;
      end
      S_ZERO: begin
        if (fill_q == LEN_OFFSET) begin
          lidx_d  = '0;
          state_d = S_LEN;
        end else begin
          push  = 1'b1;
          ret_d = S_ZERO;
        end
      end
      S_LEN: begin
        // length shifts out msb first; it is zero again after eight bytes
        push      = 1'b1;
        push_byte = len_q[63:56];
        len_d     = {len_q[55:0], 8'h00};
        lidx_d    = lidx_q + 3'd1;
        if (lidx_q == 3'd7) begin
          ret_d  = S_EMIT;
          widx_d = '0;
        end else begin
          ret_d = S_LEN;
        end
      end
      S_LOAD: begin
        core_ctrl.start = 1'b1;
        state_d         = S_WAIT;
      end
      S_WAIT: begin
        if (core_stat.done) state_d = ret_q;
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_word_d  = core_hash[widx_q];
          out_idx_d   = widx_q;
          out_last_d  = (widx_q == 3'd7);
          widx_d      = widx_q + 3'd1;
          if (widx_q == 3'd7) begin
            core_ctrl.init = 1'b1;
            state_d        = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase

    // Byte into block buffer; a full block goes to the core
    if (push) begin
      blk_d  = {blk_q[503:0], push_byte};
      fill_d = fill_q + 6'd1;
      if (fill_q == 6'd63) state_d = S_LOAD;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ret_q       <= S_IDLE;
      fill_q      <= '0;
      len_q       <= '0;
      lidx_q      <= '0;
      widx_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      fill_q      <= fill_d;
      len_q       <= len_d;
      lidx_q      <= lidx_d;
      widx_q      <= widx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Block buffer and output payload
  always_ff @(posedge clk_i) begin
    blk_q      <= blk_d;
    out_word_q <= out_word_d;
    out_idx_q  <= out_idx_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o   = out_valid_q;
  assign digest_word_o = out_word_q;
  assign word_index_o  = out_idx_q;
  assign last_word_o   = out_last_q;

`ifndef SYNTHESIS
  // New words are only taken while the core is idle
  a_idle_core: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> !core_stat.busy)
    else $error("input taken while compression runs");

  // Core completes only while the sequencer waits for it
  a_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    core_stat.done |-> (state_q == S_WAIT))
    else $error("compression done outside wait state");

  // Digest is read only after the padded message ends on a block boundary
  a_emit_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT) |-> (fill_q == 6'd0 && len_q == 64'd0))
    else $error("digest output with partial block or stale length");

  // Last flag marks exactly the final digest word
  a_last_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_word_o == (word_index_o == 3'd7)))
    else $error("last word flag out of step with index");
`endif

endmodule

// ===== tb/sha256_digest_checker.sv =====
// Watches both channels of the byte stream hasher, keeps its own SHA-256
// state, and checks every digest word that leaves the block.
module sha256_digest_checker import sbsh_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic        op_i,
  input  logic [7:0]  data_byte_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [31:0] digest_word_i,
  input  logic [2:0]  word_index_i,
  input  logic        last_word_i,
  output int          error_count_o,
  output int          pending_o,
  output int          checked_o
);

  typedef struct {
    word_t      value;
    logic [2:0] index;
    logic       last;
  } digest_entry_t;

  // Own copy of the FIPS 180-4 constants, kept apart from the package
  localparam word_t START_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // Hash state mirrored from the block
  word_t       chain [8];
  logic [63:0] byte_count;
  logic [7:0]  blk_bytes [64];
  logic [5:0]  fill;

  digest_entry_t digest_q [$];
  int            err_cnt;
  int            checked;

  assign error_count_o = err_cnt;
  assign pending_o     = digest_q.size();
  assign checked_o     = checked;

  function automatic word_t rotr(word_t x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // 64-round compression of the buffered block into the chaining words
  task automatic fold_block();
    word_t w [64];
    word_t v [8];
    word_t s0, s1, t1, t2;
    for (int i = 0; i < 16; i++) begin
      w[i] = {blk_bytes[4*i], blk_bytes[4*i+1], blk_bytes[4*i+2], blk_bytes[4*i+3]};
    end
    for (int i = 16; i < 64; i++) begin
      s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = w[i-16] + s0 + w[i-7] + s1;
    end
    v = chain;
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
           + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[i] + w[i];
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
           + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain[i] = chain[i] + v[i];
  endtask

  // Buffer one byte; fill count wraps at 64 and a full block is folded
  task automatic take_byte(input logic [7:0] b);
    blk_bytes[fill] = b;
    fill = fill + 6'd1;
    if (fill == 6'd0) fold_block();
  endtask

  // Padding, length trailer, then queue the eight digest words
  task automatic close_message();
    logic [63:0] bit_len;
    bit_len = byte_count << 3;
    take_byte(PAD_MARK);
    while (fill != LEN_OFFSET) take_byte(8'h00);
    for (int i = 0; i < 8; i++) take_byte(bit_len[63 - 8*i -: 8]);
    for (int i = 0; i < 8; i++) begin
      digest_q.push_back('{chain[i], 3'(i), (i == 7)});
    end
    chain      = START_HASH;
    byte_count = '0;
    fill       = '0;
  endtask

  // Output side checked first, then the word coming in at the same edge
  always @(posedge clk_i or negedge rst_ni) begin
    digest_entry_t exp_w;
    if (!rst_ni) begin
      chain      = START_HASH;
      byte_count = '0;
      fill       = '0;
      digest_q.delete();
      err_cnt    = 0;
      checked    = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (digest_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("%0t: digest word %h (index %0d) with none expected",
                     $realtime, digest_word_i, word_index_i);
        end else begin
          exp_w = digest_q.pop_front();
          checked++;
          if (digest_word_i !== exp_w.value || word_index_i !== exp_w.index ||
              last_word_i !== exp_w.last) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display("%0t: digest mismatch: expected %h/%0d/%b, got %h/%0d/%b",
                       $realtime, exp_w.value, exp_w.index, exp_w.last,
                       digest_word_i, word_index_i, last_word_i);
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (op_i == OP_APPEND) begin
          byte_count = byte_count + 64'd1;
          take_byte(data_byte_i);
        end else begin
          close_message();
        end
      end
    end
  end

endmodule

// ===== tb/tb_sha256_byte_stream_hasher.sv =====
module tb_sha256_byte_stream_hasher;
  import sbsh_pkg::*;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_valid    = 1'b0;
  logic        in_stall;
  logic        op          = OP_APPEND;
  logic [7:0]  data_byte   = 8'h00;
  logic        out_valid;
  logic        out_stall   = 1'b0;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  int errors;
  int pending;
  int checked;

  int idle_pct  = 0;
  int stall_pct = 0;
  int words_sent;
  int messages;

  always #5 clk = ~clk;

  sha256_byte_stream_hasher i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .op_i          (op),
    .data_byte_i   (data_byte),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .digest_word_o (digest_word),
    .word_index_o  (word_index),
    .last_word_o   (last_word)
  );

  sha256_digest_checker i_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .op_i          (op),
    .data_byte_i   (data_byte),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .digest_word_i (digest_word),
    .word_index_i  (word_index),
    .last_word_i   (last_word),
    .error_count_o (errors),
    .pending_o     (pending),
    .checked_o     (checked)
  );

  // Receiver back-pressure
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // Present one word after an optional idle gap; return once it is taken
  task automatic send_word(input logic op_val, input logic [7:0] b);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    op        <= op_val;
    data_byte <= b;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    words_sent++;
  endtask

  // Random message; lengths lean on the padding boundaries
  task automatic send_message();
    int         len;
    int         fill_kind;
    logic [7:0] b;
    case ($urandom_range(0, 9))
      0:       len = 0;
      1:       len = 55;
      2:       len = 56;
      3:       len = 63;
      4:       len = 64;
      5:       len = $urandom_range(65, 130);
      default: len = $urandom_range(1, 20);
    endcase
    fill_kind = $urandom_range(0, 7);
    for (int i = 0; i < len; i++) begin
      b = (fill_kind == 0) ? 8'hff : (fill_kind == 1) ? 8'h00 : 8'($urandom);
      send_word(OP_APPEND, b);
    end
    send_word(OP_FINISH, 8'($urandom));
    messages++;
  endtask

  // Run limit
  initial begin
    #5000000;
    $display("tb_sha256_byte_stream_hasher: done, errors");
    $finish;
  end

  initial begin
    int phase_start;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty message, then a second finish straight after
    send_word(OP_FINISH, 8'h00);
    send_word(OP_FINISH, 8'hff);
    // "abc"; its finish carries a byte that must be ignored
    send_word(OP_APPEND, 8'h61);
    send_word(OP_APPEND, 8'h62);
    send_word(OP_APPEND, 8'h63);
    send_word(OP_FINISH, 8'h5a);
    // Byte extremes
    send_word(OP_APPEND, 8'h00);
    send_word(OP_APPEND, 8'hff);
    send_word(OP_APPEND, 8'h80);
    send_word(OP_APPEND, 8'h7f);
    send_word(OP_FINISH, 8'h55);
    messages += 4;

    // Random part over the idle and back-pressure phases; the last message overshoots the budget
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 87; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 87; end
        default: begin idle_pct = 10; stall_pct = 10; end
      endcase
      phase_start = words_sent;
      while (words_sent - phase_start < 70) send_message();
    end

    // Drain; one edge first so the checker has queued the last digest
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d words in %0d messages, padding boundaries and four idle mixes",
             words_sent, messages);
    $display("Checked %0d digest words, %0d mismatches", checked, errors);
    if (errors == 0) begin
      $display("tb_sha256_byte_stream_hasher: done, clean");
    end else begin
      $display("tb_sha256_byte_stream_hasher: done, errors");
    end
    $finish;
  end

endmodule
